FILE: hdl/fgs_pkg.sv
// Shared types, constants and tables of the fuzzy gain scheduler.
package fgs_pkg;

  localparam int MF_FRAC   = 15;
  localparam int MF_W      = MF_FRAC + 1;
  localparam int NUM_SETS  = 5;
  localparam int NUM_OUT   = 6;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int SHOULDER  = 100;
  localparam int WEIGHT_W  = 18;
  localparam int DEN_W     = 18;
  localparam int PROD_W    = WEIGHT_W + MF_W;
  localparam int NUM_W     = PROD_W + 3;

  localparam logic [MF_W-1:0] MF_FULL = {1'b1, {MF_FRAC{1'b0}}};

  typedef enum logic [1:0] {
    MF_ZERO,
    MF_ONE,
    MF_DIV
  } mf_mode_t;

  typedef enum logic [2:0] {
    OUT_PVL,
    OUT_PML,
    OUT_PVS,
    OUT_PMS,
    OUT_PL,
    OUT_PS
  } out_set_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ERR_NL,
    CFG_ERR_NS,
    CFG_ERR_PS,
    CFG_ERR_PL,
    CFG_DERR_NL,
    CFG_DERR_NS,
    CFG_DERR_PS,
    CFG_DERR_PL
  } cfg_index_t;

  typedef struct packed {
    logic no_rule;
    logic sat;
  } gain_flag_t;

  localparam int BP_RESET [NUM_REGS] = '{-1000, -500, 500, 1000, -1000, -500, 500, 1000};

  localparam logic [WEIGHT_W-1:0] WEIGHT_Q16 [NUM_OUT] = '{
    18'd143163, 18'd113639, 18'd64094, 18'd69927, 18'd136151, 18'd71549
  };

  localparam out_set_t RULE_OUT [NUM_SETS][NUM_SETS] = '{
    '{OUT_PVL, OUT_PVL, OUT_PVL, OUT_PVL, OUT_PVL},
    '{OUT_PML, OUT_PML, OUT_PML, OUT_PL,  OUT_PVL},
    '{OUT_PVS, OUT_PVS, OUT_PS,  OUT_PMS, OUT_PMS},
    '{OUT_PML, OUT_PML, OUT_PML, OUT_PL,  OUT_PVL},
    '{OUT_PVL, OUT_PVL, OUT_PVL, OUT_PVL, OUT_PVL}
  };

endpackage

FILE: hdl/fgs_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with a tag carried alongside.
module fgs_div_pipe #(
  parameter int DW = 17,
  parameter int QB = 15,
  parameter int TW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [QB-1:0] in_lo,
  input  logic [DW-1:0] in_div,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [QB-1:0] out_q,
  output logic [TW-1:0] out_tag
);

  logic [DW-1:0] rem [QB];
  logic [DW-1:0] dv  [QB];
  logic [QB-1:0] lo  [QB];
  logic [QB-1:0] q   [QB];
  logic [TW-1:0] tag [QB];
  logic          vld [QB];

  logic [DW-1:0] src_rem [QB];
  logic [DW-1:0] src_div [QB];
  logic [QB-1:0] src_lo  [QB];
  logic [QB-1:0] src_q   [QB];
  logic [TW-1:0] src_tag [QB];
  logic          src_vld [QB];
  logic [DW:0]   sh      [QB];
  logic          ge      [QB];

  always_comb begin
    src_rem[0] = in_rem;
    src_div[0] = in_div;
    src_lo[0]  = in_lo;
    src_q[0]   = '0;
    src_tag[0] = in_tag;
    src_vld[0] = in_valid;
    for (int j = 1; j < QB; j++) begin
      src_rem[j] = rem[j-1];
      src_div[j] = dv[j-1];
      src_lo[j]  = lo[j-1];
      src_q[j]   = q[j-1];
      src_tag[j] = tag[j-1];
      src_vld[j] = vld[j-1];
    end
    for (int j = 0; j < QB; j++) begin
      sh[j] = {src_rem[j], src_lo[j][QB-1-j]};
      ge[j] = sh[j] >= {1'b0, src_div[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < QB; j++) vld[j] <= 1'b0;
    end else if (adv) begin
      for (int j = 0; j < QB; j++) vld[j] <= src_vld[j];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < QB; j++) begin
        rem[j] <= ge[j] ? DW'(sh[j] - {1'b0, src_div[j]}) : DW'(sh[j]);
        q[j]   <= {src_q[j][QB-2:0], ge[j]};
        dv[j]  <= src_div[j];
        lo[j]  <= src_lo[j];
        tag[j] <= src_tag[j];
      end
    end
  end

  assign out_valid = vld[QB-1];
  assign out_q     = q[QB-1];
  assign out_tag   = tag[QB-1];

endmodule

FILE: hdl/fgs_fuzz.sv
// Fuzzifier front stage: picks, per set, a fixed membership or a quotient to divide.
module fgs_fuzz #(
  parameter int SW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [SW-1:0] x,
  input  logic signed [SW-1:0] nl,
  input  logic signed [SW-1:0] ns,
  input  logic signed [SW-1:0] ps,
  input  logic signed [SW-1:0] pl,
  output logic                 out_valid,
  output fgs_pkg::mf_mode_t    mode [fgs_pkg::NUM_SETS],
  output logic [SW:0]          num  [fgs_pkg::NUM_SETS],
  output logic [SW:0]          den  [fgs_pkg::NUM_SETS]
);
  import fgs_pkg::*;

  localparam int EW = SW + 2;

  logic signed [EW-1:0] xe;
  logic signed [EW-1:0] lft [NUM_SETS];
  logic signed [EW-1:0] rgt [NUM_SETS];
  logic signed [EW-1:0] pk  [NUM_SETS];
  logic                 below;
  logic                 above;
  mf_mode_t             mode_next [NUM_SETS];
  logic [SW:0]          num_next  [NUM_SETS];
  logic [SW:0]          den_next  [NUM_SETS];

  always_comb begin
    xe     = EW'(x);
    lft[0] = EW'(nl) - EW'(SHOULDER);
    lft[1] = EW'(nl);
    lft[2] = EW'(ns);
    lft[3] = '0;
    lft[4] = EW'(ps);
    rgt[0] = EW'(ns);
    rgt[1] = '0;
    rgt[2] = EW'(ps);
    rgt[3] = EW'(pl);
    rgt[4] = EW'(pl) + EW'(SHOULDER);
    pk[0]  = EW'(nl);
    pk[1]  = EW'(ns);
    pk[2]  = '0;
    pk[3]  = EW'(ps);
    pk[4]  = EW'(pl);
    below  = xe <= EW'(nl);
    above  = xe > EW'(pl);
    for (int k = 0; k < NUM_SETS; k++) begin
      mode_next[k] = MF_ZERO;
      num_next[k]  = '0;
      den_next[k]  = '0;
      if (below) begin
        if (k == 0) mode_next[k] = MF_ONE;
      end else if (above) begin
        if (k == NUM_SETS - 1) mode_next[k] = MF_ONE;
      end else if (xe == pk[k]) begin
        mode_next[k] = MF_ONE;
      end else if (xe > lft[k] && xe < pk[k]) begin
        mode_next[k] = MF_DIV;
        num_next[k]  = (SW+1)'(xe - lft[k]);
        den_next[k]  = (SW+1)'(pk[k] - lft[k]);
      end else if (xe > pk[k] && xe < rgt[k]) begin
        mode_next[k] = MF_DIV;
        num_next[k]  = (SW+1)'(rgt[k] - xe);
        den_next[k]  = (SW+1)'(rgt[k] - pk[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_SETS; k++) begin
        mode[k] <= mode_next[k];
        num[k]  <= num_next[k];
        den[k]  <= den_next[k];
      end
    end
  end

endmodule

FILE: hdl/fgs_rule_agg.sv
// Rule evaluation, max aggregation, weighting and setup of the gain division.
module fgs_rule_agg #(
  parameter int G = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic [fgs_pkg::MF_W-1:0] me [fgs_pkg::NUM_SETS],
  input  logic [fgs_pkg::MF_W-1:0] md [fgs_pkg::NUM_SETS],
  output logic                     out_valid,
  output logic [fgs_pkg::DEN_W-1:0] rem0,
  output logic [G+1:0]             lo,
  output logic [fgs_pkg::DEN_W-1:0] den,
  output fgs_pkg::gain_flag_t      flag
);
  import fgs_pkg::*;

  localparam int FW  = NUM_W + G + 1;
  localparam int NNW = FW - 16;
  localparam int HW  = NNW - G - 2;

  logic              v1, v2, v3, v4, v5;
  logic [MF_W-1:0]   s      [NUM_SETS][NUM_SETS];
  logic [MF_W-1:0]   rowmax [NUM_OUT][NUM_SETS];
  logic [MF_W-1:0]   rowmax_next [NUM_OUT][NUM_SETS];
  logic [MF_W-1:0]   agg    [NUM_OUT];
  logic [MF_W-1:0]   agg_next [NUM_OUT];
  logic [PROD_W-1:0] prod   [NUM_OUT];
  logic [DEN_W-1:0]  den4, den4_next, den5;
  logic [NUM_W-1:0]  num5, num5_next;
  logic [FW-1:0]     full;
  logic [NNW-1:0]    nn;
  logic [HW-1:0]     hi;

  always_comb begin
    for (int o = 0; o < NUM_OUT; o++) begin
      for (int i = 0; i < NUM_SETS; i++) begin
        rowmax_next[o][i] = '0;
        for (int j = 0; j < NUM_SETS; j++) begin
          if (RULE_OUT[i][j] == out_set_t'(o) && s[i][j] > rowmax_next[o][i]) begin
            rowmax_next[o][i] = s[i][j];
          end
        end
      end
    end
    for (int o = 0; o < NUM_OUT; o++) begin
      agg_next[o] = '0;
      for (int i = 0; i < NUM_SETS; i++) begin
        if (rowmax[o][i] > agg_next[o]) agg_next[o] = rowmax[o][i];
      end
    end
    den4_next = '0;
    for (int o = 0; o < NUM_OUT; o++) den4_next = den4_next + DEN_W'(agg[o]);
    num5_next = '0;
    for (int o = 0; o < NUM_OUT; o++) num5_next = num5_next + NUM_W'(prod[o]);
    full = (FW'(num5) << G) + (FW'(den5) << 15);
    nn   = full[FW-1:16];
    hi   = nn[NNW-1:G+2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_SETS; i++) begin
        for (int j = 0; j < NUM_SETS; j++) begin
          s[i][j] <= (me[i] < md[j]) ? me[i] : md[j];
        end
      end
      rowmax <= rowmax_next;
      agg    <= agg_next;
      for (int o = 0; o < NUM_OUT; o++) begin
        prod[o] <= PROD_W'(WEIGHT_Q16[o]) * PROD_W'(agg[o]);
      end
      den4         <= den4_next;
      num5         <= num5_next;
      den5         <= den4;
      rem0         <= nn[G+2 +: DEN_W];
      lo           <= nn[G+1:0];
      den          <= den5;
      flag.no_rule <= den5 == '0;
      flag.sat     <= hi >= HW'(den5);
    end
  end

endmodule

FILE: hdl/fuzzy_gain_scheduler.sv
// Fuzzy gain scheduler: an error and a change-of-error sample are fuzzified into five
// triangular sets each, 25 min rules are merged by max into six output sets, and the
// gain is the round-half-up weighted average of six fixed weights in unsigned
// Q2.GAIN_FRAC_BITS (zero with no_rule_fired set when no rule fires). One request is
// taken every cycle while in_stall is low; each result passes through the 15-stage
// membership dividers and the GAIN_FRAC_BITS + 2 stage gain divider. Out stall freezes
// the whole pipeline and shows up on in_stall in the same cycle while a result waits.
// Breakpoint registers should be written only while the pipeline is empty.
module fuzzy_gain_scheduler #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [fgs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic signed [SAMPLE_WIDTH-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]    err_sample,
  input  logic signed [SAMPLE_WIDTH-1:0]    derr_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [GAIN_FRAC_BITS+1:0]         gain,
  output logic                              no_rule_fired
);
  import fgs_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int G  = GAIN_FRAC_BITS;

  logic                 adv;
  logic signed [SW-1:0] bp [NUM_REGS];

  logic        fe_valid, fd_valid;
  mf_mode_t    fe_mode [NUM_SETS];
  mf_mode_t    fd_mode [NUM_SETS];
  logic [SW:0] fe_num  [NUM_SETS];
  logic [SW:0] fe_den  [NUM_SETS];
  logic [SW:0] fd_num  [NUM_SETS];
  logic [SW:0] fd_den  [NUM_SETS];

  logic               de_valid [NUM_SETS];
  logic               dd_valid [NUM_SETS];
  logic [MF_FRAC-1:0] de_q     [NUM_SETS];
  logic [MF_FRAC-1:0] dd_q     [NUM_SETS];
  logic [1:0]         de_tag   [NUM_SETS];
  logic [1:0]         dd_tag   [NUM_SETS];
  logic [MF_W-1:0]    me       [NUM_SETS];
  logic [MF_W-1:0]    md       [NUM_SETS];

  logic             ag_valid;
  logic [DEN_W-1:0] ag_rem0, ag_den;
  logic [G+1:0]     ag_lo;
  gain_flag_t       ag_flag;
  logic             gd_valid;
  logic [G+1:0]     gd_q;
  gain_flag_t       gd_flag;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_REGS; r++) bp[r] <= SW'(BP_RESET[r]);
    end else if (cfg_we) begin
      bp[cfg_index] <= cfg_data;
    end
  end

  fgs_fuzz #(.SW(SW)) u_fuzz_err (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(in_valid), .x(err_sample),
    .nl(bp[CFG_ERR_NL]), .ns(bp[CFG_ERR_NS]), .ps(bp[CFG_ERR_PS]), .pl(bp[CFG_ERR_PL]),
    .out_valid(fe_valid), .mode(fe_mode), .num(fe_num), .den(fe_den)
  );

  fgs_fuzz #(.SW(SW)) u_fuzz_derr (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(in_valid), .x(derr_sample),
    .nl(bp[CFG_DERR_NL]), .ns(bp[CFG_DERR_NS]), .ps(bp[CFG_DERR_PS]), .pl(bp[CFG_DERR_PL]),
    .out_valid(fd_valid), .mode(fd_mode), .num(fd_num), .den(fd_den)
  );

  for (genvar k = 0; k < NUM_SETS; k++) begin : g_mf
    fgs_div_pipe #(.DW(SW + 1), .QB(MF_FRAC), .TW(2)) u_div_err (
      .clk(clk), .rst(rst), .adv(adv), .in_valid(fe_valid),
      .in_rem(fe_num[k]), .in_lo('0), .in_div(fe_den[k]), .in_tag(fe_mode[k]),
      .out_valid(de_valid[k]), .out_q(de_q[k]), .out_tag(de_tag[k])
    );
    fgs_div_pipe #(.DW(SW + 1), .QB(MF_FRAC), .TW(2)) u_div_derr (
      .clk(clk), .rst(rst), .adv(adv), .in_valid(fd_valid),
      .in_rem(fd_num[k]), .in_lo('0), .in_div(fd_den[k]), .in_tag(fd_mode[k]),
      .out_valid(dd_valid[k]), .out_q(dd_q[k]), .out_tag(dd_tag[k])
    );
  end

  always_comb begin
    for (int k = 0; k < NUM_SETS; k++) begin
      case (mf_mode_t'(de_tag[k]))
        MF_ONE:  me[k] = MF_FULL;
        MF_DIV:  me[k] = {1'b0, de_q[k]};
        default: me[k] = '0;
      endcase
      case (mf_mode_t'(dd_tag[k]))
        MF_ONE:  md[k] = MF_FULL;
        MF_DIV:  md[k] = {1'b0, dd_q[k]};
        default: md[k] = '0;
      endcase
    end
  end

  fgs_rule_agg #(.G(G)) u_rule_agg (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(de_valid[0] && dd_valid[0]),
    .me(me), .md(md),
    .out_valid(ag_valid), .rem0(ag_rem0), .lo(ag_lo), .den(ag_den), .flag(ag_flag)
  );

  fgs_div_pipe #(.DW(DEN_W), .QB(G + 2), .TW($bits(gain_flag_t))) u_div_gain (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(ag_valid),
    .in_rem(ag_rem0), .in_lo(ag_lo), .in_div(ag_den), .in_tag(ag_flag),
    .out_valid(gd_valid), .out_q(gd_q), .out_tag(gd_flag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= gd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (gd_flag.no_rule) begin
        gain <= '0;
      end else if (gd_flag.sat) begin
        gain <= '1;
      end else begin
        gain <= gd_q;
      end
      no_rule_fired <= gd_flag.no_rule;
    end
  end

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output register can advance");

  a_no_rule_zero_gain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && no_rule_fired) |-> (gain == '0))
    else $error("gain nonzero with no rule fired");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(gain) && $stable(no_rule_fired)))
    else $error("stalled result changed");
`endif

endmodule
